>>> rtl/six_axis_dual_tone_motion_generator_macros.svh
// Assertion macros shared by the motion generator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SIX_AXIS_DUAL_TONE_MOTION_GENERATOR_MACROS_SVH
`define SIX_AXIS_DUAL_TONE_MOTION_GENERATOR_MACROS_SVH

// antecedent in this cycle implies consequent in this cycle
`define SADTMG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define SADTMG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sadtmg_pkg.sv
// Package for the six-axis motion generator: widths, register indexes,
// phase offsets and the sine table builder. No dependencies.
`default_nettype none
package sadtmg_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int OUT_BITS       = 16;
    localparam int IDX_BITS       = 32;
    localparam int AMP_BITS       = 16;
    localparam int GAIN_BITS      = 16;
    localparam int SINE_W         = 16;
    localparam int MAG_W          = 15;
    localparam int QUARTER        = 1 << (SINE_ADDR_BITS - 2);
    localparam int RR_W           = SINE_ADDR_BITS - 1;
    localparam int NUM_OFFS       = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRI_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWELL_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWELL_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAVE_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_AMP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_AMP    = 3'd5;

    // axis phase offsets: none, quarter, eighth, three eighths of a turn
    localparam logic [PHASE_BITS-1:0] OFF_Q = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS-1:0] OFF_E = PHASE_BITS'(1) << (PHASE_BITS - 3);

    // sine offset slots
    localparam int SLOT_0  = 0;
    localparam int SLOT_Q  = 1;
    localparam int SLOT_E  = 2;
    localparam int SLOT_3E = 3;

    // quarter-wave magnitude by Taylor series, evaluated at elaboration
    function automatic logic [MAG_W-1:0] sine_calc(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] val;
        x    = (64'(r) * HALF_PI_Q30) >> (SINE_ADDR_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            unique case (k)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        val = ($unsigned(sum) + 64'd16384) >> 15;
        if (val > 64'd32767) begin
            val = 64'd32767;
        end
        return val[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/sadtmg_phase.sv
// Phase stage: sample index times both phase steps, wrapping.
// Uses sadtmg_pkg.
`default_nettype none
module sadtmg_phase
    import sadtmg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [IDX_BITS-1:0]   i_index,
    input  wire logic [31:0]           i_pri_step,
    input  wire logic [31:0]           i_swell_step,
    output logic      [PHASE_BITS-1:0] o_pri_phase,
    output logic      [PHASE_BITS-1:0] o_swell_phase
);
    logic [63:0] n_pri;
    logic [63:0] n_swell;
    logic [PHASE_BITS-1:0] r_pri;
    logic [PHASE_BITS-1:0] r_swell;

    assign n_pri   = 64'(i_index) * 64'(i_pri_step);
    assign n_swell = 64'(i_index) * 64'(i_swell_step);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pri   <= n_pri[PHASE_BITS-1:0];
            r_swell <= n_swell[PHASE_BITS-1:0];
        end
    end

    assign o_pri_phase   = r_pri;
    assign o_swell_phase = r_swell;
endmodule
`default_nettype wire

>>> rtl/sadtmg_sine.sv
// Sine stage: four offset phases looked up in a quarter-wave table.
// Uses sadtmg_pkg (table builder, offsets).
`default_nettype none
module sadtmg_sine
    import sadtmg_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [PHASE_BITS-1:0]    i_phase,
    output logic signed [SINE_W-1:0]      o_sine [NUM_OFFS]
);
    localparam logic [MAG_W-1:0] SINE_TOP = sine_calc(QUARTER);

    logic [MAG_W-1:0] w_lut [QUARTER];
    for (genvar g = 0; g < QUARTER; g++) begin : g_lut
        assign w_lut[g] = sine_calc(g);
    end

    logic signed [SINE_W-1:0] n_sine [NUM_OFFS];
    logic signed [SINE_W-1:0] r_sine [NUM_OFFS];

    always_comb begin
        logic [PHASE_BITS-1:0]     ph;
        logic [SINE_ADDR_BITS-1:0] addr;
        logic [RR_W-1:0]           rr;
        logic [MAG_W-1:0]          mag;
        logic [PHASE_BITS-1:0]     offs [NUM_OFFS];
        offs[SLOT_0]  = '0;
        offs[SLOT_Q]  = OFF_Q;
        offs[SLOT_E]  = OFF_E;
        offs[SLOT_3E] = OFF_E + OFF_Q;
        for (int j = 0; j < NUM_OFFS; j++) begin
            ph   = i_phase + offs[j];
            addr = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
            rr   = {1'b0, addr[SINE_ADDR_BITS-3:0]};
            if (addr[SINE_ADDR_BITS-2]) begin
                rr = RR_W'(QUARTER) - rr;
            end
            // only the top of the quarter falls outside the table
            if (rr[RR_W-1]) begin
                mag = SINE_TOP;
            end else begin
                mag = w_lut[rr[RR_W-2:0]];
            end
            if (addr[SINE_ADDR_BITS-1]) begin
                n_sine[j] = -$signed({1'b0, mag});
            end else begin
                n_sine[j] = $signed({1'b0, mag});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= n_sine;
        end
    end

    assign o_sine = r_sine;
endmodule
`default_nettype wire

>>> rtl/sadtmg_axis.sv
// One axis: amplitude products, swell gain, rounding, offset, saturation.
// Three register stages. Uses sadtmg_pkg.
`default_nettype none
module sadtmg_axis
    import sadtmg_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [AMP_BITS-1:0]     i_amp,
    input  wire logic [GAIN_BITS-1:0]    i_gain,
    input  wire logic signed [15:0]      i_offset,
    input  wire logic signed [SINE_W-1:0] i_s1,
    input  wire logic signed [SINE_W-1:0] i_s2,
    output logic signed [OUT_BITS-1:0]   o_value,
    output logic                         o_clip
);
    localparam int PW = AMP_BITS + SINE_W + 1;    // amp * sine
    localparam int SW = PW + GAIN_BITS + 2;       // full sum
    localparam int RW = SW - 29;                  // after rounding
    localparam logic signed [RW:0] HI = (RW+1)'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [RW:0] LO = -HI - (RW+1)'(1);

    logic signed [PW-1:0] r_m1;
    logic signed [PW-1:0] r_m2;
    logic signed [SW-1:0] r_t1;
    logic signed [SW-1:0] r_t2;
    logic signed [15:0]   r_off;
    logic signed [SW-1:0] n_sum;
    logic signed [RW:0]   n_val;
    logic signed [OUT_BITS-1:0] r_value;
    logic                 r_clip;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1  <= PW'($signed({1'b0, i_amp}) * i_s1);
            r_m2  <= PW'($signed({1'b0, i_amp}) * i_s2);
            r_t1  <= SW'(r_m1) <<< 14;
            r_t2  <= SW'($signed({1'b0, i_gain}) * r_m2);
            r_off <= i_offset;
        end
    end

    // round half up, then the offset
    always_comb begin
        logic signed [SW-1:0] shifted;
        n_sum   = r_t1 + r_t2 + SW'(1 << 28);
        shifted = n_sum >>> 29;
        n_val   = $signed({shifted[RW-1], shifted[RW-1:0]}) + (RW+1)'(r_off);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_val > HI) begin
                r_value <= HI[OUT_BITS-1:0];
                r_clip  <= 1'b1;
            end else if (n_val < LO) begin
                r_value <= LO[OUT_BITS-1:0];
                r_clip  <= 1'b1;
            end else begin
                r_value <= n_val[OUT_BITS-1:0];
                r_clip  <= 1'b0;
            end
        end
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;
endmodule
`default_nettype wire

>>> rtl/six_axis_dual_tone_motion_generator.sv
// Channel   Dir  Payload
// s_axis    in   tdata[31:0] sample_index
// m_axis    out  tdata surge,sway,heave,roll,pitch,yaw (16 b each); tuser clipped
// cfg       in   i_cfg_index register number, i_cfg_data value
// Five register stages: phase multiply, sine lookup, amplitude multiply,
// swell gain multiply, sum/round/saturate. One item per clock unless the output stalls.
// The whole pipe advances together when the output stage is empty or taken,
// so a stall holds every stage and drops nothing. Synchronous active-low
// reset clears the valid bits and the config registers; config ready is always high.
`default_nettype none
`include "six_axis_dual_tone_motion_generator_macros.svh"
module six_axis_dual_tone_motion_generator
    import sadtmg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,  // [31:0] sample_index
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // surge[15:0] sway[31:16] heave[47:32] roll[63:48] pitch[79:64] yaw[95:80]
    output logic [6*OUT_BITS-1:0]      m_axis_tdata,
    output logic                       m_axis_tuser,  // [0] clipped
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int STAGES = 5;

    logic [31:0]          r_pri_step;
    logic [31:0]          r_swell_step;
    logic [GAIN_BITS-1:0] r_gain;
    logic signed [15:0]   r_heave_off;
    logic [47:0]          r_trans_amp;
    logic [47:0]          r_rot_amp;
    logic [STAGES-1:0]    r_vld;
    logic                 w_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_step   <= '0;
            r_swell_step <= '0;
            r_gain       <= '0;
            r_heave_off  <= '0;
            r_trans_amp  <= '0;
            r_rot_amp    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PRI_STEP:   r_pri_step   <= i_cfg_data[31:0];
                REG_SWELL_STEP: r_swell_step <= i_cfg_data[31:0];
                REG_SWELL_GAIN: r_gain       <= i_cfg_data[15:0];
                REG_HEAVE_OFF:  r_heave_off  <= $signed(i_cfg_data[15:0]);
                REG_TRANS_AMP:  r_trans_amp  <= i_cfg_data[47:0];
                REG_ROT_AMP:    r_rot_amp    <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign w_en          = !r_vld[STAGES-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], s_axis_tvalid};
        end
    end

    logic [PHASE_BITS-1:0]    w_pri_phase;
    logic [PHASE_BITS-1:0]    w_swell_phase;
    logic signed [SINE_W-1:0] w_s1 [NUM_OFFS];
    logic signed [SINE_W-1:0] w_s2 [NUM_OFFS];

    sadtmg_phase u_phase (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_index       (s_axis_tdata),
        .i_pri_step    (r_pri_step),
        .i_swell_step  (r_swell_step),
        .o_pri_phase   (w_pri_phase),
        .o_swell_phase (w_swell_phase)
    );

    sadtmg_sine u_sine_pri (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_pri_phase),
        .o_sine  (w_s1)
    );

    sadtmg_sine u_sine_swell (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_swell_phase),
        .o_sine  (w_s2)
    );

    logic [AMP_BITS-1:0]       w_amp  [6];
    logic signed [OUT_BITS-1:0] w_val [6];
    logic [5:0]                w_clip;

    assign w_amp[0] = r_trans_amp[15:0];
    assign w_amp[1] = r_trans_amp[31:16];
    assign w_amp[2] = r_trans_amp[47:32];
    assign w_amp[3] = r_rot_amp[15:0];
    assign w_amp[4] = r_rot_amp[31:16];
    assign w_amp[5] = r_rot_amp[47:32];

    for (genvar a = 0; a < 6; a++) begin : g_axis
        localparam int SL = (a == 1 || a == 3) ? SLOT_Q :
                            (a == 4) ? SLOT_E : (a == 5) ? SLOT_3E : SLOT_0;
        sadtmg_axis u_axis (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_amp    (w_amp[a]),
            .i_gain   (r_gain),
            .i_offset ((a == 2) ? r_heave_off : 16'sd0),
            .i_s1     (w_s1[SL]),
            .i_s2     (w_s2[SL]),
            .o_value  (w_val[a]),
            .o_clip   (w_clip[a])
        );
    end

    assign m_axis_tdata = {w_val[5], w_val[4], w_val[3], w_val[2], w_val[1], w_val[0]};
    assign m_axis_tuser = |w_clip;

    `SADTMG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "waiting result changed")
    `SADTMG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        !w_en, $stable(r_vld), "pipe moved during stall")
    `SADTMG_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n,
        w_en && s_axis_tvalid, r_vld[0], "accepted item not in first stage")
    `SADTMG_ASSERT_NEXT(a_drain_to_out, i_clk, i_rst_n,
        w_en && r_vld[STAGES-2], m_axis_tvalid, "item lost before output")
endmodule
`default_nettype wire
